### hw/rtl/rde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_pkg: shared types, codes and tables
// Phase codes, pattern lookups and the character code conversion tables.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 16;
    localparam int PROG_W = 4;
    localparam int PHASE_W = 2;

    localparam logic [PHASE_W-1:0] PH_ITEM = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DESC = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TEXT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

    localparam logic [PROG_W-1:0] ITEM_LEN = 4'd6;
    localparam logic [PROG_W-1:0] DESC_LEN = 4'd13;

    localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;

    // control from the matcher to the result stage
    typedef struct packed {
        logic emit;   // byte belongs to the text
        logic term;   // byte is the terminating '<'
    } rde_ctl_t;

    function automatic logic [BYTE_W-1:0] item_char(input logic [PROG_W-1:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            4'd0:    c = 8'h3C; // <
            4'd1:    c = 8'h69; // i
            4'd2:    c = 8'h74; // t
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h6D; // m
            4'd5:    c = 8'h3E; // >
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] desc_char(input logic [PROG_W-1:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            4'd0:    c = 8'h3C; // <
            4'd1:    c = 8'h64; // d
            4'd2:    c = 8'h65; // e
            4'd3:    c = 8'h73; // s
            4'd4:    c = 8'h63; // c
            4'd5:    c = 8'h72; // r
            4'd6:    c = 8'h69; // i
            4'd7:    c = 8'h70; // p
            4'd8:    c = 8'h74; // t
            4'd9:    c = 8'h69; // i
            4'd10:   c = 8'h6F; // o
            4'd11:   c = 8'h6E; // n
            4'd12:   c = 8'h3E; // >
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Windows-1251 upper half to DOS 866
    localparam logic [BYTE_W-1:0] WIN_TO_DOS [0:127] = '{
        8'h5F,8'h5F,8'h27,8'h5F,8'h22,8'h3A,8'hC5,8'hD8,
        8'h5F,8'h25,8'h5F,8'h3C,8'h5F,8'h5F,8'h5F,8'h5F,
        8'h5F,8'h27,8'h27,8'h22,8'h22,8'h07,8'h2D,8'h2D,
        8'h5F,8'h54,8'h5F,8'h3E,8'h5F,8'h5F,8'h5F,8'h5F,
        8'hFF,8'hF6,8'hF7,8'h5F,8'hFD,8'h83,8'hB3,8'h15,
        8'hF0,8'h63,8'hF2,8'h3C,8'hBF,8'h2D,8'h52,8'hF4,
        8'hF8,8'h2B,8'h49,8'h69,8'hA3,8'hE7,8'h14,8'hFA,
        8'hF1,8'hFC,8'hF3,8'h3E,8'h5F,8'h5F,8'h5F,8'hF5,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,
        8'h90,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,
        8'h98,8'h99,8'h9A,8'h9B,8'h9C,8'h9D,8'h9E,8'h9F,
        8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
        8'hA8,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,
        8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,
        8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF
    };

    // DOS 866 upper half to Unicode
    localparam logic [CODE_W-1:0] DOS_TO_UNI [0:127] = '{
        16'h0410,16'h0411,16'h0412,16'h0413,16'h0414,16'h0415,16'h0416,16'h0417,
        16'h0418,16'h0419,16'h041A,16'h041B,16'h041C,16'h041D,16'h041E,16'h041F,
        16'h0420,16'h0421,16'h0422,16'h0423,16'h0424,16'h0425,16'h0426,16'h0427,
        16'h0428,16'h0429,16'h042A,16'h042B,16'h042C,16'h042D,16'h042E,16'h042F,
        16'h0430,16'h0431,16'h0432,16'h0433,16'h0434,16'h0435,16'h0436,16'h0437,
        16'h0438,16'h0439,16'h043A,16'h043B,16'h043C,16'h043D,16'h043E,16'h043F,
        16'h002D,16'h002D,16'h002D,16'h00A6,16'h002B,16'h00A6,16'h00A6,16'h00AC,
        16'h00AC,16'h00A6,16'h00A6,16'h00AC,16'h002D,16'h002D,16'h002D,16'h00AC,
        16'h004C,16'h002B,16'h0054,16'h002B,16'h002D,16'h002B,16'h00A6,16'h00A6,
        16'h004C,16'h0433,16'h00A6,16'h0054,16'h00A6,16'h003D,16'h002B,16'h00A6,
        16'h00A6,16'h0054,16'h0054,16'h004C,16'h004C,16'h002D,16'h0433,16'h002B,
        16'h002B,16'h002D,16'h002D,16'h002D,16'h002D,16'h00A6,16'h00A6,16'h002D,
        16'h0440,16'h0441,16'h0442,16'h0443,16'h0444,16'h0445,16'h0446,16'h0447,
        16'h0448,16'h0449,16'h044A,16'h044B,16'h044C,16'h044D,16'h044E,16'h044F,
        16'h0401,16'h0451,16'h0404,16'h0454,16'h0407,16'h0457,16'h040E,16'h045E,
        16'h00B0,16'h2022,16'h00B7,16'h0076,16'h2116,16'h00A4,16'h00A6,16'h00A0
    };

endpackage

`default_nettype wire

### hw/rtl/rde_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_convert: byte to 16-bit character code
// ASCII passes through; upper half goes Win1251 -> DOS866 -> Unicode.
// ----------------------------------------------------------------------------
module rde_convert (
    input  wire logic [rde_pkg::BYTE_W-1:0] byte_in,
    output logic      [rde_pkg::CODE_W-1:0] code_out
);
    import rde_pkg::*;

    logic [BYTE_W-1:0] dos;

    always_comb begin
        dos = WIN_TO_DOS[byte_in[BYTE_W-2:0]];
        if (!byte_in[BYTE_W-1]) begin
            code_out = {{(CODE_W-BYTE_W){1'b0}}, byte_in};
        end else if (!dos[BYTE_W-1]) begin
            code_out = {{(CODE_W-BYTE_W){1'b0}}, dos};
        end else begin
            code_out = DOS_TO_UNI[dos[BYTE_W-2:0]];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rde_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_matcher: tag search and phase tracking
// Finds <item> then <description>, flags text bytes and the terminator.
// ----------------------------------------------------------------------------
module rde_matcher (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,      // process the held byte
    input  wire logic [rde_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                       last_in,
    output rde_pkg::rde_ctl_t               ctl
);
    import rde_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PROG_W-1:0]  prog_reg, prog_next;

    logic [PROG_W-1:0] len, k, k1;
    logic [BYTE_W-1:0] pat;
    logic              hit, done, is_lt;

    always_comb begin
        is_lt = (byte_in == CH_LT);
        len   = (phase_reg == PH_ITEM) ? ITEM_LEN : DESC_LEN;
        k     = (prog_reg >= len) ? '0 : prog_reg;
        pat   = (phase_reg == PH_ITEM) ? item_char(k) : desc_char(k);
        hit   = (pat == byte_in);
        k1    = k + 1'b1;
        done  = hit && (k1 == len);

        ctl.emit = (phase_reg == PH_TEXT);
        ctl.term = is_lt;

        phase_next = phase_reg;
        prog_next  = prog_reg;
        if (step) begin
            case (phase_reg)
                PH_ITEM, PH_DESC: begin
                    if (hit) begin
                        prog_next = done ? '0 : k1;
                    end else begin
                        prog_next = is_lt ? PROG_W'(1) : '0;
                    end
                    if (done) begin
                        phase_next = (phase_reg == PH_ITEM) ? PH_DESC : PH_TEXT;
                    end
                end
                PH_TEXT: begin
                    if (is_lt) begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
            if (last_in) begin
                phase_next = PH_ITEM;
                prog_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ITEM;
            prog_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            prog_reg  <= prog_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rss_description_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle; back-to-back with no bubbles while m_tready holds.
// Bytes outside the description text are consumed and produce no result request.
// Reset (aresetn low, synchronous): clears input/output valids and returns the
// matcher to the <item> search.
// ----------------------------------------------------------------------------
// rss_description_extractor: RSS description text extractor
// Streams document bytes, finds <item><description>, emits converted
// characters of the description up to the closing '<'.
// ----------------------------------------------------------------------------
module rss_description_extractor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    // result requests
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] char_code, [16] char_valid, [23:17] zero
    output logic             m_tlast    // text_end
);
    import rde_pkg::*;

    // Input register stage
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Result register stage
    logic              out_vld_reg, out_vld_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_end_reg, out_end_next;

    logic              advance;   // result register can take a new value
    logic              step;      // held byte is processed this cycle
    logic              s_acc;
    rde_ctl_t          ctl;
    logic [CODE_W-1:0] conv_code;

    // A held byte moves on when the result register is empty or being drained;
    // the input register refills in the same cycle.
    assign advance  = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    rde_matcher u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .ctl     (ctl)
    );

    rde_convert u_convert (
        .byte_in  (in_byte_reg),
        .code_out (conv_code)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_acc) begin
            in_vld_next = 1'b1;
        end else if (step) begin
            in_vld_next = 1'b0;
        end

        out_vld_next   = out_vld_reg;
        out_code_next  = out_code_reg;
        out_valid_next = out_valid_reg;
        out_end_next   = out_end_reg;
        if (advance) begin
            // Only text-phase bytes yield a result; the rest drain the register.
            out_vld_next = step && ctl.emit;
            if (ctl.term) begin
                // closing '<': empty character, end of text
                out_code_next  = '0;
                out_valid_next = 1'b0;
                out_end_next   = 1'b1;
            end else begin
                out_code_next  = conv_code;
                out_valid_next = 1'b1;
                out_end_next   = in_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_code_reg  <= out_code_next;
        out_valid_reg <= out_valid_next;
        out_end_reg   <= out_end_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_valid_reg, out_code_reg};
    assign m_tlast  = out_end_reg;

endmodule

`default_nettype wire

### tb/rss_description_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_description_extractor_tb: self-checking bench for the description extractor
// Feeds byte documents (directed corner cases, then random well-formed and broken
// ones) with random gaps and back-pressure; a scoreboard predicts every character
// request and checks the result stream in order.
// ----------------------------------------------------------------------------
module rss_description_extractor_tb;

    import rde_pkg::*;

    localparam int RAND_BYTES = 1250;
    localparam int IDLE_PCT   = 38;
    localparam int MAX_SHOWN  = 10;

    // Windows-1251 upper half to DOS 866
    localparam logic [7:0] CP1251_TO_CP866 [0:127] = '{
        8'h5F,8'h5F,8'h27,8'h5F,8'h22,8'h3A,8'hC5,8'hD8,
        8'h5F,8'h25,8'h5F,8'h3C,8'h5F,8'h5F,8'h5F,8'h5F,
        8'h5F,8'h27,8'h27,8'h22,8'h22,8'h07,8'h2D,8'h2D,
        8'h5F,8'h54,8'h5F,8'h3E,8'h5F,8'h5F,8'h5F,8'h5F,
        8'hFF,8'hF6,8'hF7,8'h5F,8'hFD,8'h83,8'hB3,8'h15,
        8'hF0,8'h63,8'hF2,8'h3C,8'hBF,8'h2D,8'h52,8'hF4,
        8'hF8,8'h2B,8'h49,8'h69,8'hA3,8'hE7,8'h14,8'hFA,
        8'hF1,8'hFC,8'hF3,8'h3E,8'h5F,8'h5F,8'h5F,8'hF5,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,
        8'h90,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,
        8'h98,8'h99,8'h9A,8'h9B,8'h9C,8'h9D,8'h9E,8'h9F,
        8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
        8'hA8,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,
        8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,
        8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF
    };

    // DOS 866 upper half to UCS-2
    localparam logic [15:0] CP866_TO_UCS [0:127] = '{
        16'h0410,16'h0411,16'h0412,16'h0413,16'h0414,16'h0415,16'h0416,16'h0417,
        16'h0418,16'h0419,16'h041A,16'h041B,16'h041C,16'h041D,16'h041E,16'h041F,
        16'h0420,16'h0421,16'h0422,16'h0423,16'h0424,16'h0425,16'h0426,16'h0427,
        16'h0428,16'h0429,16'h042A,16'h042B,16'h042C,16'h042D,16'h042E,16'h042F,
        16'h0430,16'h0431,16'h0432,16'h0433,16'h0434,16'h0435,16'h0436,16'h0437,
        16'h0438,16'h0439,16'h043A,16'h043B,16'h043C,16'h043D,16'h043E,16'h043F,
        16'h002D,16'h002D,16'h002D,16'h00A6,16'h002B,16'h00A6,16'h00A6,16'h00AC,
        16'h00AC,16'h00A6,16'h00A6,16'h00AC,16'h002D,16'h002D,16'h002D,16'h00AC,
        16'h004C,16'h002B,16'h0054,16'h002B,16'h002D,16'h002B,16'h00A6,16'h00A6,
        16'h004C,16'h0433,16'h00A6,16'h0054,16'h00A6,16'h003D,16'h002B,16'h00A6,
        16'h00A6,16'h0054,16'h0054,16'h004C,16'h004C,16'h002D,16'h0433,16'h002B,
        16'h002B,16'h002D,16'h002D,16'h002D,16'h002D,16'h00A6,16'h00A6,16'h002D,
        16'h0440,16'h0441,16'h0442,16'h0443,16'h0444,16'h0445,16'h0446,16'h0447,
        16'h0448,16'h0449,16'h044A,16'h044B,16'h044C,16'h044D,16'h044E,16'h044F,
        16'h0401,16'h0451,16'h0404,16'h0454,16'h0407,16'h0457,16'h040E,16'h045E,
        16'h00B0,16'h2022,16'h00B7,16'h0076,16'h2116,16'h00A4,16'h00A6,16'h00A0
    };

    typedef struct packed {
        logic [15:0] code;
        logic        valid;
        logic        text_end;
    } char_result_t;

    // Predicts the character requests of the extractor and checks them in order.
    class text_checker;
        logic [PHASE_W-1:0] phase;
        int                 matched;
        string              item_tag = "<item>";
        string              desc_tag = "<description>";
        char_result_t       pending_chars [$];
        int                 err_count;

        function new();
            phase     = PH_ITEM;
            matched   = 0;
            err_count = 0;
        endfunction

        function logic [15:0] to_unicode(logic [7:0] b);
            logic [7:0] d;
            if (!b[7]) return {8'h00, b};
            d = CP1251_TO_CP866[b[6:0]];
            if (!d[7]) return {8'h00, d};
            return CP866_TO_UCS[d[6:0]];
        endfunction

        // one matcher step; returns 1 when the whole tag has been seen
        function bit tag_step(string tag, int len, logic [7:0] b);
            int k;
            k = (matched >= len) ? 0 : matched;
            if (tag[k] == b) begin
                k++;
                matched = (k == len) ? 0 : k;
                return (k == len);
            end
            matched = (b == CH_LT) ? 1 : 0;
            return 0;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            char_result_t r;
            case (phase)
                PH_ITEM: begin
                    if (tag_step(item_tag, int'(ITEM_LEN), b)) phase = PH_DESC;
                end
                PH_DESC: begin
                    if (tag_step(desc_tag, int'(DESC_LEN), b)) phase = PH_TEXT;
                end
                PH_TEXT: begin
                    if (b == CH_LT) begin
                        r.code = 16'h0000; r.valid = 1'b0; r.text_end = 1'b1;
                        phase = PH_DONE;
                    end else begin
                        r.code = to_unicode(b); r.valid = 1'b1; r.text_end = last;
                    end
                    pending_chars.push_back(r);
                end
                default: ;
            endcase
            // last byte always restarts the tag search
            if (last) begin
                phase   = PH_ITEM;
                matched = 0;
            end
        endfunction

        function void check_char(logic [23:0] tdata, logic tlast);
            char_result_t r;
            logic [23:0]  want;
            if (pending_chars.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("%0t: unexpected result request tdata=%h tlast=%b",
                             $realtime, tdata, tlast);
                return;
            end
            r    = pending_chars.pop_front();
            want = {7'd0, r.valid, r.code};
            if (tdata !== want || tlast !== r.text_end) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("%0t: mismatch exp tdata=%h tlast=%b, got tdata=%h tlast=%b",
                             $realtime, want, r.text_end, tdata, tlast);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    text_checker sb = new();
    bit          no_idle = 1'b0;  // set during the full-rate stretch
    int          bytes_sent = 0;

    rss_description_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // result monitor; values seen here are the ones from before the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
    end

    // Drive one byte request and wait for its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_str(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // random bytes, some '<' and tag fragments so the matcher restarts a lot
    task automatic send_noise(input int n, input bit last_at_end);
        string frag;
        int    pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                frag = ($urandom_range(1)) ? "<item>" : "<description>";
                send_str(frag.substr(0, $urandom_range(frag.len() - 2)), 1'b0);
            end
            if (pick < 20) send_byte(CH_LT, last_at_end && (i == n - 1));
            else send_byte(8'($urandom_range(255)), last_at_end && (i == n - 1));
        end
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LT);
        return b;
    endfunction

    task automatic send_document();
        int kind;
        int len;
        int tail;
        kind = $urandom_range(99);
        send_noise($urandom_range(6), 1'b0);
        if (kind < 8) begin
            // broken document: noise only
            send_noise($urandom_range(15) + 1, 1'b1);
            return;
        end
        if (kind < 12) begin
            // last mark on the closing bracket of the item tag
            send_str("<item>", 1'b1);
            return;
        end
        send_str("<item>", 1'b0);
        if (kind < 18) begin
            // document ends in the middle of the description search
            send_noise($urandom_range(6), 1'b0);
            send_str("<descrip", 1'b0);
            send_byte(text_byte(), 1'b1);
            return;
        end
        send_noise($urandom_range(3), 1'b0);
        send_str("<description>", 1'b0);
        len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
        for (int i = 0; i < len; i++) send_byte(text_byte(), 1'b0);
        case ($urandom_range(3))
            0: send_byte(text_byte(), 1'b1);  // last mark inside the text
            1: send_byte(CH_LT, 1'b1);         // terminator carries the last mark
            default: begin
                send_byte(CH_LT, 1'b0);
                // bytes after the terminator are ignored, tags included
                if ($urandom_range(3) == 0) send_str("<item><description>", 1'b0);
                tail = $urandom_range(5) + 1;
                send_noise(tail, 1'b1);
            end
        endcase
    endtask

    initial begin
        int docs;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: broken tag, full header, code extremes, terminator, ignored byte
        send_str("<it", 1'b0);
        send_str("<item>", 1'b0);
        send_str("<description>", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(8'h41, 1'b1);

        docs = 0;
        while (bytes_sent < RAND_BYTES) begin
            no_idle = (docs >= 12 && docs < 22);
            send_document();
            docs++;
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending_chars.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (sb.err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
